### sv/rtd_code_to_temperature_macros.svh
// Assertion macros for the RTD code to temperature block.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef RTD_CODE_TO_TEMPERATURE_MACROS_SVH
`define RTD_CODE_TO_TEMPERATURE_MACROS_SVH

// same-cycle implication, off during reset
`define RTDC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtdc: implication check failed");

// response a fixed number of cycles later, off during reset
`define RTDC_ASSERT_DLY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error("rtdc: delayed response check failed");

`endif

### sv/rtdc_pkg.sv
// Shared constants, types and functions for the RTD code to temperature block.
// Holds the fixed-point curve coefficients, datapath widths and the item flag struct.
// No dependencies.
package rtdc_pkg;

	localparam int DEF_SEARCH_STEPS   = 22;
	localparam int DEF_CODE_BITS      = 15;
	localparam int DEF_TEMP_FRAC_BITS = 13;

	localparam int REG_W     = 16;
	localparam int TEMP_W    = 23;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NOM = CFG_IDX_W'(1);

	localparam logic [REG_W-1:0] REF_RESET = 16'd4300;
	localparam logic [REG_W-1:0] NOM_RESET = 16'd1000;

	// pipeline depth of one bisection cell
	localparam int CELL_STAGES = 8;

	// curve scale: p = 1.0 sits at 2^40
	localparam int P_FRAC = 40;

	// coefficients: A * 2^40, B * 2^48, C * 2^60
	localparam logic signed [33:0] COEF_A = 34'sd4297221295;
	localparam logic signed [28:0] COEF_B = -29'sd162551799;
	localparam logic signed [23:0] COEF_C = -24'sd4822671;

	// datapath widths (signed)
	localparam int T20_W   = 30;
	localparam int SQ_W    = 60;
	localparam int T2_W    = 34;
	localparam int AF_W    = 64;
	localparam int A_W     = 44;
	localparam int PB_W    = 63;
	localparam int B_W     = 39;
	localparam int P3_W    = 64;
	localparam int T3_W    = 35;
	localparam int TM_W    = 29;
	localparam int PD_W    = 64;
	localparam int D_W     = 36;
	localparam int PC_W    = 60;
	localparam int C_W     = 32;
	localparam int P_W     = 44;
	localparam int CURVE_W = 61;

	// floor shifts of the curve terms
	localparam int SH_T2 = 24;
	localparam int SH_A  = 20;
	localparam int SH_B  = 24;
	localparam int SH_T3 = 20;
	localparam int SH_D  = 28;
	localparam int SH_C  = 28;

	localparam logic signed [T20_W-1:0] T20_HUND = 30'sd104857600;
	localparam logic signed [P_W-1:0]   P_ONE    = P_W'(64'sd1 <<< P_FRAC);

	// curve polynomial p(T) at a Q.20 temperature, elaboration only
	function automatic longint cvd_p(input longint t20);
		longint t2;
		longint t3;
		longint d;
		longint p;
		t2 = (t20 * t20) >>> SH_T2;
		p  = 64'sd1 <<< P_FRAC;
		p  = p + ((longint'(COEF_A) * t20) >>> SH_A);
		p  = p + ((longint'(COEF_B) * t2) >>> SH_B);
		if (t20 < 0) begin
			t3 = (t2 * t20) >>> SH_T3;
			d  = (t3 * (t20 - (64'sd100 <<< 20))) >>> SH_D;
			p  = p + ((longint'(COEF_C) * d) >>> SH_C);
		end
		return p;
	endfunction

	localparam logic signed [P_W-1:0] P_LO = P_W'(cvd_p(-(64'sd50 <<< 20)));
	localparam logic signed [P_W-1:0] P_HI = P_W'(cvd_p(64'sd300 <<< 20));

	typedef struct packed {
		logic valid;
		logic below;
		logic above;
	} item_flags_t;

endpackage

### sv/rtdc_front.sv
// Front end of the RTD code to temperature block: scales the code to a target
// resistance and checks it against the curve at both range ends.
// Depends on rtdc_pkg.
module rtdc_front #(
	parameter int CODE_BITS = rtdc_pkg::DEF_CODE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    take,
	input  logic [CODE_BITS-1:0]                    adc_code,
	input  logic [rtdc_pkg::REG_W-1:0]              ref_res,
	input  logic [rtdc_pkg::REG_W-1:0]              nom_res,
	output rtdc_pkg::item_flags_t                   out_fl,
	output logic signed [rtdc_pkg::CURVE_W-1:0]     out_tgt
);

	localparam int CURVE_W = rtdc_pkg::CURVE_W;
	localparam int PROD_W  = CODE_BITS + rtdc_pkg::REG_W;
	localparam int TGT_SH  = rtdc_pkg::P_FRAC - CODE_BITS;
	localparam int NOM_SW  = rtdc_pkg::REG_W + 1;

	logic                      valid_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic signed [CURVE_W-1:0] lob_s1;
	logic signed [CURVE_W-1:0] hib_s1;

	rtdc_pkg::item_flags_t     fl_s2;
	logic signed [CURVE_W-1:0] tgt_s2;

	logic signed [NOM_SW-1:0]  nom_s;
	logic signed [CURVE_W-1:0] tgt_w;
	logic                      below_w;
	logic                      above_w;

	assign nom_s   = $signed({1'b0, nom_res});
	assign tgt_w   = $signed(CURVE_W'(prod_s1) << TGT_SH);
	assign below_w = tgt_w < lob_s1;
	assign above_w = !below_w && (tgt_w > hib_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fl_s2    <= '0;
		end else begin
			valid_s1    <= take;
			fl_s2.valid <= valid_s1;
			fl_s2.below <= below_w;
			fl_s2.above <= above_w;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(adc_code) * PROD_W'(ref_res);
		lob_s1  <= CURVE_W'(nom_s) * CURVE_W'(rtdc_pkg::P_LO);
		hib_s1  <= CURVE_W'(nom_s) * CURVE_W'(rtdc_pkg::P_HI);
		tgt_s2  <= tgt_w;
	end

	assign out_fl  = fl_s2;
	assign out_tgt = tgt_s2;

endmodule

### sv/rtdc_cell.sv
// One bisection cell: evaluates the curve at the interval midpoint over an
// eight-stage pipeline and halves the interval. Depends on rtdc_pkg.
module rtdc_cell #(
	parameter int TEMP_FRAC_BITS = rtdc_pkg::DEF_TEMP_FRAC_BITS,
	localparam int UW = $clog2(350 * (2 ** TEMP_FRAC_BITS) + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rtdc_pkg::REG_W-1:0]          nom_res,
	input  rtdc_pkg::item_flags_t               in_fl,
	input  logic [UW-1:0]                       in_lo,
	input  logic [UW-1:0]                       in_hi,
	input  logic signed [rtdc_pkg::CURVE_W-1:0] in_tgt,
	output rtdc_pkg::item_flags_t               out_fl,
	output logic [UW-1:0]                       out_lo,
	output logic [UW-1:0]                       out_hi,
	output logic signed [rtdc_pkg::CURVE_W-1:0] out_tgt
);

	localparam int T20_W   = rtdc_pkg::T20_W;
	localparam int SQ_W    = rtdc_pkg::SQ_W;
	localparam int T2_W    = rtdc_pkg::T2_W;
	localparam int AF_W    = rtdc_pkg::AF_W;
	localparam int A_W     = rtdc_pkg::A_W;
	localparam int PB_W    = rtdc_pkg::PB_W;
	localparam int B_W     = rtdc_pkg::B_W;
	localparam int P3_W    = rtdc_pkg::P3_W;
	localparam int T3_W    = rtdc_pkg::T3_W;
	localparam int TM_W    = rtdc_pkg::TM_W;
	localparam int PD_W    = rtdc_pkg::PD_W;
	localparam int D_W     = rtdc_pkg::D_W;
	localparam int PC_W    = rtdc_pkg::PC_W;
	localparam int C_W     = rtdc_pkg::C_W;
	localparam int P_W     = rtdc_pkg::P_W;
	localparam int CURVE_W = rtdc_pkg::CURVE_W;
	localparam int NOM_SW  = rtdc_pkg::REG_W + 1;
	localparam int UW1     = UW + 1;
	localparam int T20_SH  = 20 - TEMP_FRAC_BITS;

	localparam logic signed [UW:0] BASE = UW1'(50 * (2 ** TEMP_FRAC_BITS));

	rtdc_pkg::item_flags_t fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7, fl_s8;

	logic [UW-1:0] lo_s1, lo_s2, lo_s3, lo_s4, lo_s5, lo_s6, lo_s7, lo_s8;
	logic [UW-1:0] hi_s1, hi_s2, hi_s3, hi_s4, hi_s5, hi_s6, hi_s7, hi_s8;
	logic signed [CURVE_W-1:0] tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5, tgt_s6, tgt_s7;
	logic signed [CURVE_W-1:0] tgt_s8;

	logic signed [T20_W-1:0]   t20_s1, t20_s2;
	logic signed [SQ_W-1:0]    sq_s2;
	logic signed [AF_W-1:0]    af_s2;
	logic signed [TM_W-1:0]    tm_s2, tm_s3;
	logic                      neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [PB_W-1:0]    pb_s3;
	logic signed [P3_W-1:0]    p3_s3;
	logic signed [A_W-1:0]     a_s3;
	logic signed [PD_W-1:0]    pd_s4;
	logic signed [B_W-1:0]     b_s4;
	logic signed [P_W-1:0]     ab_s4, ab_s5;
	logic signed [PC_W-1:0]    pc_s5;
	logic signed [P_W-1:0]     p_s6;
	logic signed [CURVE_W-1:0] cv_s7;

	logic [UW:0]               sum_in;
	logic signed [UW:0]        t_in;
	logic signed [T20_W-1:0]   t20_in;
	logic signed [T20_W-1:0]   tm_full;
	logic signed [T2_W-1:0]    t2_w;
	logic signed [A_W-1:0]     a_w;
	logic signed [T3_W-1:0]    t3_w;
	logic signed [B_W-1:0]     b_w;
	logic signed [D_W-1:0]     d_w;
	logic signed [C_W-1:0]     c_w;
	logic signed [NOM_SW-1:0]  nom_s;
	logic [UW:0]               sum_7;
	logic [UW-1:0]             mid_7;
	logic                      lt_7;

	// midpoint of the incoming interval, as a Q.20 temperature
	assign sum_in = {1'b0, in_lo} + {1'b0, in_hi};
	assign t_in   = $signed({1'b0, sum_in[UW:1]}) - BASE;
	assign t20_in = T20_W'(t_in) <<< T20_SH;

	assign tm_full = t20_s1 - rtdc_pkg::T20_HUND;
	assign t2_w    = $signed(sq_s2[rtdc_pkg::SH_T2 +: T2_W]);
	assign a_w     = $signed(af_s2[rtdc_pkg::SH_A +: A_W]);
	assign t3_w    = $signed(p3_s3[rtdc_pkg::SH_T3 +: T3_W]);
	assign b_w     = $signed(pb_s3[rtdc_pkg::SH_B +: B_W]);
	assign d_w     = $signed(pd_s4[rtdc_pkg::SH_D +: D_W]);
	assign c_w     = $signed(pc_s5[rtdc_pkg::SH_C +: C_W]);
	assign nom_s   = $signed({1'b0, nom_res});

	// recompute the midpoint next to the compare rather than carry it
	assign sum_7 = {1'b0, lo_s7} + {1'b0, hi_s7};
	assign mid_7 = sum_7[UW:1];
	assign lt_7  = cv_s7 < tgt_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s1 <= '0;
			fl_s2 <= '0;
			fl_s3 <= '0;
			fl_s4 <= '0;
			fl_s5 <= '0;
			fl_s6 <= '0;
			fl_s7 <= '0;
			fl_s8 <= '0;
		end else begin
			fl_s1 <= in_fl;
			fl_s2 <= fl_s1;
			fl_s3 <= fl_s2;
			fl_s4 <= fl_s3;
			fl_s5 <= fl_s4;
			fl_s6 <= fl_s5;
			fl_s7 <= fl_s6;
			fl_s8 <= fl_s7;
		end
	end

	always_ff @(posedge clk) begin
		// interval and target ride along
		lo_s1  <= in_lo;
		hi_s1  <= in_hi;
		tgt_s1 <= in_tgt;
		lo_s2  <= lo_s1;
		hi_s2  <= hi_s1;
		tgt_s2 <= tgt_s1;
		lo_s3  <= lo_s2;
		hi_s3  <= hi_s2;
		tgt_s3 <= tgt_s2;
		lo_s4  <= lo_s3;
		hi_s4  <= hi_s3;
		tgt_s4 <= tgt_s3;
		lo_s5  <= lo_s4;
		hi_s5  <= hi_s4;
		tgt_s5 <= tgt_s4;
		lo_s6  <= lo_s5;
		hi_s6  <= hi_s5;
		tgt_s6 <= tgt_s5;
		lo_s7  <= lo_s6;
		hi_s7  <= hi_s6;
		tgt_s7 <= tgt_s6;

		t20_s1 <= t20_in;

		sq_s2  <= SQ_W'(t20_s1) * SQ_W'(t20_s1);
		af_s2  <= AF_W'(rtdc_pkg::COEF_A) * AF_W'(t20_s1);
		tm_s2  <= $signed(tm_full[TM_W-1:0]);
		t20_s2 <= t20_s1;
		neg_s2 <= t20_s1[T20_W-1];

		pb_s3  <= PB_W'(rtdc_pkg::COEF_B) * PB_W'(t2_w);
		p3_s3  <= P3_W'(t2_w) * P3_W'(t20_s2);
		a_s3   <= a_w;
		tm_s3  <= tm_s2;
		neg_s3 <= neg_s2;

		pd_s4  <= PD_W'(t3_w) * PD_W'(tm_s3);
		b_s4   <= b_w;
		ab_s4  <= rtdc_pkg::P_ONE + P_W'(a_s3);
		neg_s4 <= neg_s3;

		pc_s5  <= PC_W'(rtdc_pkg::COEF_C) * PC_W'(d_w);
		ab_s5  <= ab_s4 + P_W'(b_s4);
		neg_s5 <= neg_s4;

		// cubic term only applies below zero degrees
		p_s6   <= neg_s5 ? (ab_s5 + P_W'(c_w)) : ab_s5;

		cv_s7  <= CURVE_W'(nom_s) * CURVE_W'(p_s6);

		lo_s8  <= lt_7 ? mid_7 : lo_s7;
		hi_s8  <= lt_7 ? hi_s7 : mid_7;
		tgt_s8 <= tgt_s7;
	end

	assign out_fl  = fl_s8;
	assign out_lo  = lo_s8;
	assign out_hi  = hi_s8;
	assign out_tgt = tgt_s8;

endmodule

### sv/rtd_code_to_temperature.sv
// Performs SEARCH_STEPS halvings, 22 by default.
// Throughput: one item per cycle; busy stays low. Each halving is one
// eight-stage cell (the curve's multiplier chain), two front stages scale and
// range-check the code, and one output register holds the result.
// Reset clears the pipeline valid bits and loads 4300 and 1000 ohms.
module rtd_code_to_temperature #(
	parameter int SEARCH_STEPS   = rtdc_pkg::DEF_SEARCH_STEPS,
	parameter int CODE_BITS      = rtdc_pkg::DEF_CODE_BITS,
	parameter int TEMP_FRAC_BITS = rtdc_pkg::DEF_TEMP_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [CODE_BITS-1:0]                adc_code,
	input  logic                                cfg_we,
	input  logic [rtdc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rtdc_pkg::REG_W-1:0]          cfg_data,
	output logic                                done,
	output logic signed [rtdc_pkg::TEMP_W-1:0]  temperature,
	output logic                                below_range,
	output logic                                above_range
);

	localparam int UW      = $clog2(350 * (2 ** TEMP_FRAC_BITS) + 1);
	localparam int UW1     = UW + 1;
	localparam int TEMP_W  = rtdc_pkg::TEMP_W;
	localparam int CURVE_W = rtdc_pkg::CURVE_W;

	localparam logic [UW-1:0]      SPAN  = UW'(350 * (2 ** TEMP_FRAC_BITS));
	localparam logic signed [UW:0] BASE  = UW1'(50 * (2 ** TEMP_FRAC_BITS));
	localparam logic signed [UW:0] T_TOP = UW1'(300 * (2 ** TEMP_FRAC_BITS));

	logic [rtdc_pkg::REG_W-1:0] ref_q;
	logic [rtdc_pkg::REG_W-1:0] nom_q;

	rtdc_pkg::item_flags_t     fl_c  [SEARCH_STEPS+1];
	logic [UW-1:0]             lo_c  [SEARCH_STEPS+1];
	logic [UW-1:0]             hi_c  [SEARCH_STEPS+1];
	logic signed [CURVE_W-1:0] tgt_c [SEARCH_STEPS+1];

	logic                      take;
	logic [UW:0]               sum_f;
	logic signed [UW:0]        t_f;
	logic signed [TEMP_W-1:0]  temp_d;

	logic                      done_q;
	logic signed [TEMP_W-1:0]  temperature_q;
	logic                      below_q;
	logic                      above_q;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= rtdc_pkg::REF_RESET;
			nom_q <= rtdc_pkg::NOM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				rtdc_pkg::REG_REF: ref_q <= cfg_data;
				rtdc_pkg::REG_NOM: nom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rtdc_front #(
		.CODE_BITS (CODE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.adc_code (adc_code),
		.ref_res  (ref_q),
		.nom_res  (nom_q),
		.out_fl   (fl_c[0]),
		.out_tgt  (tgt_c[0])
	);

	// full search interval enters the first cell
	assign lo_c[0] = '0;
	assign hi_c[0] = SPAN;

	for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_cell
		rtdc_cell #(
			.TEMP_FRAC_BITS (TEMP_FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.nom_res (nom_q),
			.in_fl   (fl_c[i]),
			.in_lo   (lo_c[i]),
			.in_hi   (hi_c[i]),
			.in_tgt  (tgt_c[i]),
			.out_fl  (fl_c[i+1]),
			.out_lo  (lo_c[i+1]),
			.out_hi  (hi_c[i+1]),
			.out_tgt (tgt_c[i+1])
		);
	end

	assign sum_f = {1'b0, lo_c[SEARCH_STEPS]} + {1'b0, hi_c[SEARCH_STEPS]};
	assign t_f   = $signed({1'b0, sum_f[UW:1]}) - BASE;

	// saturate out-of-range resistances to the interval ends
	always_comb begin
		if (fl_c[SEARCH_STEPS].below) begin
			temp_d = TEMP_W'(-BASE);
		end else if (fl_c[SEARCH_STEPS].above) begin
			temp_d = TEMP_W'(T_TOP);
		end else begin
			temp_d = TEMP_W'(t_f);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fl_c[SEARCH_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		temperature_q <= temp_d;
		below_q       <= fl_c[SEARCH_STEPS].below;
		above_q       <= fl_c[SEARCH_STEPS].above;
	end

	assign done        = done_q;
	assign temperature = temperature_q;
	assign below_range = below_q;
	assign above_range = above_q;

endmodule

### sv/rtdc_checker.sv
// Port-level checker for the RTD code to temperature block, bound to the top.
// Depends on rtdc_pkg and rtd_code_to_temperature_macros.svh.
`include "rtd_code_to_temperature_macros.svh"

module rtdc_checker #(
	parameter int SEARCH_STEPS   = rtdc_pkg::DEF_SEARCH_STEPS,
	parameter int TEMP_FRAC_BITS = rtdc_pkg::DEF_TEMP_FRAC_BITS
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [rtdc_pkg::TEMP_W-1:0] temperature,
	input logic                               below_range,
	input logic                               above_range
);

	localparam int TEMP_W = rtdc_pkg::TEMP_W;
	localparam int LAT    = rtdc_pkg::CELL_STAGES * SEARCH_STEPS + 3;

	localparam logic [TEMP_W-1:0] T_LOW  = TEMP_W'(-(50 * (2 ** TEMP_FRAC_BITS)));
	localparam logic [TEMP_W-1:0] T_HIGH = TEMP_W'(300 * (2 ** TEMP_FRAC_BITS));

	`RTDC_ASSERT_DLY(a_item_gives_result, start && !busy, LAT, done)
	`RTDC_ASSERT_IMP(a_result_has_item, done, $past(start && !busy, LAT))
	`RTDC_ASSERT_IMP(a_flags_exclusive, done, !(below_range && above_range))
	`RTDC_ASSERT_IMP(a_below_saturates, done && below_range, temperature == T_LOW)
	`RTDC_ASSERT_IMP(a_above_saturates, done && above_range, temperature == T_HIGH)

endmodule

bind rtd_code_to_temperature rtdc_checker #(
	.SEARCH_STEPS   (SEARCH_STEPS),
	.TEMP_FRAC_BITS (TEMP_FRAC_BITS)
) u_rtdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.temperature (temperature),
	.below_range (below_range),
	.above_range (above_range)
);
